// File: rtl/core/pbwt_prefix_divergence_update_top_defines.svh
// Assertion macros for the pbwt prefix/divergence block checker.
// Both expect signals named clk and rst_n in the scope of use.
`ifndef PBWT_PREFIX_DIVERGENCE_UPDATE_TOP_DEFINES_SVH
`define PBWT_PREFIX_DIVERGENCE_UPDATE_TOP_DEFINES_SVH

// same-cycle implication
`define PDU_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PDU_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/pdu_pkg.sv
package pdu_pkg;

  localparam int MAX_HAPS = 256;
  localparam int HAP_W    = $clog2(MAX_HAPS);
  localparam int CNT_W    = $clog2(MAX_HAPS + 1);
  localparam int SITE_W   = 16;
  localparam int CFG_W    = 9;
  localparam int OP_W     = 2;

  localparam logic [SITE_W-1:0] SITE_MAX     = {SITE_W{1'b1}};
  localparam logic [CFG_W-1:0]  NUM_HAPS_RST = CFG_W'(256);

  // command queue, front to back
  localparam int CQ_DEPTH = 4;
  localparam int CQ_PTR_W = $clog2(CQ_DEPTH);
  localparam int CQ_CNT_W = $clog2(CQ_DEPTH + 1);

  // result queue
  localparam int RQ_DEPTH = 2;
  localparam int RQ_PTR_W = $clog2(RQ_DEPTH);
  localparam int RQ_CNT_W = $clog2(RQ_DEPTH + 1);

  typedef enum logic [OP_W-1:0] {
    OP_LOAD    = 2'd0,
    OP_CLOSE   = 2'd1,
    OP_READ    = 2'd2,
    OP_RESTART = 2'd3
  } op_t;

  typedef struct packed {
    op_t              op;
    logic [HAP_W-1:0] idx;
    logic             allele;
  } cmd_t;

  typedef struct packed {
    logic [HAP_W-1:0]  hap;
    logic [SITE_W-1:0] div;
    logic [SITE_W-1:0] sites;
  } rsp_t;

  typedef struct packed {
    logic [HAP_W-1:0]  hap;
    logic [SITE_W-1:0] div;
  } ord_ent_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_WALK,
    ST_COPY,
    ST_FIN
  } back_state_t;

endpackage

// File: rtl/core/pbwt_prefix_divergence_update_top.sv
// PBWT prefix order / divergence array update. Keeps the sorted haplotype
// order and divergence array of up to 256 haplotypes. Beats on the input
// queue: op 0 loads one allele of the current site, op 1 closes the site
// (stable partition into allele-0 then allele-1 haplotypes, divergence
// update, site count +1 saturating), op 2 reads the haplotype and divergence
// at a sorted position plus the site count, op 3 restarts to identity order,
// zero divergence and site 0 (alleles and num_haplotypes kept). Only op 2
// makes a result beat. A close walks the first n = min(num_haplotypes, 256)
// sorted positions over the order memory's single read port (one entry per
// cycle, 3-stage order/allele pipeline), then, when some haplotype carries
// allele 1, copies the allele-1 entries through its single write port.
// Commands are taken one at a time; a 4-deep command queue lets the input
// side keep accepting while the back end works, and a 2-deep result queue
// holds reads until popped. cfg_ready is always high; write num_haplotypes
// only while idle. Alleles never loaded read back as undefined.
module pbwt_prefix_divergence_update_top (
  input  logic                       clk,
  input  logic                       rst_n,
  // input queue
  input  logic                       in_push,
  output logic                       in_full,
  input  logic [pdu_pkg::OP_W-1:0]   in_op,
  input  logic [pdu_pkg::HAP_W-1:0]  in_hap_index,
  input  logic                       in_allele,
  // result queue
  output logic                       out_empty,
  input  logic                       out_pop,
  output logic [pdu_pkg::HAP_W-1:0]  out_hap_at_position,
  output logic [pdu_pkg::SITE_W-1:0] out_divergence,
  output logic [pdu_pkg::SITE_W-1:0] out_sites_done,
  // config
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [pdu_pkg::CFG_W-1:0]  cfg_num_haplotypes
);
  import pdu_pkg::*;

  logic [CFG_W-1:0] num_haps_r;
  logic             cmd_valid, cmd_pop;
  cmd_t             cmd;
  logic             rsp_push, rsp_full;
  rsp_t             rsp;

  // config register, always open
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_haps_r <= NUM_HAPS_RST;
    end else if (cfg_valid && cfg_ready) begin
      num_haps_r <= cfg_num_haplotypes;
    end
  end

  // front: take beats, decode, queue
  pdu_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_push      (in_push),
    .in_full      (in_full),
    .in_op        (in_op),
    .in_hap_index (in_hap_index),
    .in_allele    (in_allele),
    .cmd_valid    (cmd_valid),
    .cmd          (cmd),
    .cmd_pop      (cmd_pop)
  );

  // back: memories, site walk and copy
  pdu_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .num_haps  (num_haps_r),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .rsp_full  (rsp_full),
    .rsp_push  (rsp_push),
    .rsp       (rsp)
  );

  // read results wait here until popped
  pdu_rsp_q u_rsp_q (
    .clk                 (clk),
    .rst_n               (rst_n),
    .rsp_push            (rsp_push),
    .rsp                 (rsp),
    .rsp_full            (rsp_full),
    .out_empty           (out_empty),
    .out_pop             (out_pop),
    .out_hap_at_position (out_hap_at_position),
    .out_divergence      (out_divergence),
    .out_sites_done      (out_sites_done)
  );

endmodule

// File: rtl/core/pdu_front.sv
module pdu_front (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_push,
  output logic                      in_full,
  input  logic [pdu_pkg::OP_W-1:0]  in_op,
  input  logic [pdu_pkg::HAP_W-1:0] in_hap_index,
  input  logic                      in_allele,
  output logic                      cmd_valid,
  output pdu_pkg::cmd_t             cmd,
  input  logic                      cmd_pop
);
  import pdu_pkg::*;

  cmd_t                q_r [CQ_DEPTH];
  logic [CQ_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [CQ_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CQ_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                push, pop;
  cmd_t                cmd_in;

  // classify the raw beat into a command
  always_comb begin
    cmd_in.op     = op_t'(in_op);
    cmd_in.idx    = in_hap_index;
    cmd_in.allele = in_allele;
  end

  assign in_full   = (cnt_r == CQ_CNT_W'(CQ_DEPTH));
  assign cmd_valid = (cnt_r != '0);
  assign cmd       = q_r[rd_ptr_r];
  assign push      = in_push && !in_full;
  assign pop       = cmd_pop && cmd_valid;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + CQ_PTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + CQ_PTR_W'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + CQ_CNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CQ_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= cmd_in;
    end
  end

endmodule

// File: rtl/core/pdu_rsp_q.sv
module pdu_rsp_q (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       rsp_push,
  input  pdu_pkg::rsp_t              rsp,
  output logic                       rsp_full,
  output logic                       out_empty,
  input  logic                       out_pop,
  output logic [pdu_pkg::HAP_W-1:0]  out_hap_at_position,
  output logic [pdu_pkg::SITE_W-1:0] out_divergence,
  output logic [pdu_pkg::SITE_W-1:0] out_sites_done
);
  import pdu_pkg::*;

  rsp_t                q_r [RQ_DEPTH];
  logic [RQ_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [RQ_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [RQ_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                push, pop;
  rsp_t                head;

  assign rsp_full  = (cnt_r == RQ_CNT_W'(RQ_DEPTH));
  assign out_empty = (cnt_r == '0);
  assign push      = rsp_push && !rsp_full;
  assign pop       = out_pop && !out_empty;

  assign head                = q_r[rd_ptr_r];
  assign out_hap_at_position = head.hap;
  assign out_divergence      = head.div;
  assign out_sites_done      = head.sites;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + RQ_PTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + RQ_PTR_W'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + RQ_CNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - RQ_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= rsp;
    end
  end

endmodule

// File: rtl/core/pdu_back.sv
module pdu_back (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [pdu_pkg::CFG_W-1:0] num_haps,
  input  logic                      cmd_valid,
  input  pdu_pkg::cmd_t             cmd,
  output logic                      cmd_pop,
  input  logic                      rsp_full,
  output logic                      rsp_push,
  output pdu_pkg::rsp_t             rsp
);
  import pdu_pkg::*;

  back_state_t state_r, state_nxt;

  // storage
  logic              alle_mem [MAX_HAPS];
  logic [HAP_W-1:0]  ord_mem  [MAX_HAPS];
  logic [SITE_W-1:0] div_mem  [MAX_HAPS];
  ord_ent_t          one_mem  [MAX_HAPS];
  logic [MAX_HAPS-1:0] vld_r;   // entry written since reset/restart

  logic [SITE_W-1:0] site_r;
  logic [CNT_W-1:0]  j_r, c0_r, c1_r, k_r;
  logic [SITE_W-1:0] run0_r, run1_r;
  logic              b_v_r, c_v_r, k_v_r;

  // stage A output (order read)
  logic [HAP_W-1:0]  ord_q_r;
  logic [SITE_W-1:0] div_q_r;
  logic              vld_q_r;
  logic [HAP_W-1:0]  idx_q_r;
  // stage C input (allele read)
  logic              all_q_r;
  logic [HAP_W-1:0]  h_c_r;
  logic [SITE_W-1:0] d_c_r;
  // copy stage
  ord_ent_t          one_q_r;

  logic [CNT_W-1:0]  n_eff;
  logic [SITE_W-1:0] site_start;
  logic [HAP_W-1:0]  h_b;
  logic [SITE_W-1:0] d_b;
  logic [SITE_W-1:0] m0, m1;
  logic              walk_done, copy_done;

  logic              issue_a, copy_issue;
  logic [HAP_W-1:0]  rd_addr;
  logic              ord_we;
  ord_ent_t          ord_wdata;
  logic              zero_wr, one_wr;
  logic              go_walk, do_load, do_restart;

  assign n_eff      = (num_haps > CFG_W'(MAX_HAPS)) ? CNT_W'(MAX_HAPS) : CNT_W'(num_haps);
  assign site_start = (site_r == SITE_MAX) ? site_r : site_r + SITE_W'(1);

  // unwritten entries read as identity order, zero divergence
  assign h_b = vld_q_r ? ord_q_r : idx_q_r;
  assign d_b = vld_q_r ? div_q_r : '0;

  assign m0 = (d_c_r > run0_r) ? d_c_r : run0_r;
  assign m1 = (d_c_r > run1_r) ? d_c_r : run1_r;

  assign walk_done = (j_r == n_eff) && !b_v_r && !c_v_r;
  assign copy_done = (k_r == c1_r) && !k_v_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (cmd_valid) begin
          unique case (cmd.op)
            OP_READ:  if (!rsp_full) state_nxt = ST_READ;
            OP_CLOSE: state_nxt = ST_WALK;
            default:  state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_READ: state_nxt = ST_IDLE;
      ST_WALK: begin
        if (walk_done) begin
          state_nxt = (c1_r != '0) ? ST_COPY : ST_FIN;
        end
      end
      ST_COPY: if (copy_done) state_nxt = ST_FIN;
      ST_FIN:  state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_pop    = 1'b0;
    go_walk    = 1'b0;
    do_load    = 1'b0;
    do_restart = 1'b0;
    rd_addr    = j_r[HAP_W-1:0];
    rsp_push   = 1'b0;
    issue_a    = 1'b0;
    copy_issue = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        rd_addr = cmd.idx;
        if (cmd_valid) begin
          unique case (cmd.op)
            OP_READ:    cmd_pop = !rsp_full;
            OP_CLOSE: begin
              cmd_pop = 1'b1;
              go_walk = 1'b1;
            end
            OP_LOAD: begin
              cmd_pop = 1'b1;
              do_load = 1'b1;
            end
            OP_RESTART: begin
              cmd_pop    = 1'b1;
              do_restart = 1'b1;
            end
            default: cmd_pop = 1'b0;
          endcase
        end
      end
      ST_READ: rsp_push   = 1'b1;
      ST_WALK: issue_a    = (j_r != n_eff);
      ST_COPY: copy_issue = (k_r != c1_r);
      ST_FIN:  rsp_push   = 1'b0;
      default: rsp_push   = 1'b0;
    endcase

    zero_wr   = c_v_r && !all_q_r;
    one_wr    = c_v_r && all_q_r;
    ord_we    = zero_wr || k_v_r;
    ord_wdata = k_v_r ? one_q_r : ord_ent_t'{hap: h_c_r, div: m0};
  end

  assign rsp.hap   = h_b;
  assign rsp.div   = d_b;
  assign rsp.sites = site_r;

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      vld_r   <= '0;
      site_r  <= '0;
      j_r     <= '0;
      c0_r    <= '0;
      c1_r    <= '0;
      k_r     <= '0;
      b_v_r   <= 1'b0;
      c_v_r   <= 1'b0;
      k_v_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      b_v_r   <= issue_a;
      c_v_r   <= b_v_r;
      k_v_r   <= copy_issue;
      if (go_walk) begin
        j_r  <= '0;
        c0_r <= '0;
        c1_r <= '0;
        k_r  <= '0;
      end else begin
        if (issue_a)    j_r  <= j_r + CNT_W'(1);
        if (ord_we)     c0_r <= c0_r + CNT_W'(1);
        if (one_wr)     c1_r <= c1_r + CNT_W'(1);
        if (copy_issue) k_r  <= k_r + CNT_W'(1);
      end
      if (do_restart) begin
        vld_r  <= '0;
        site_r <= '0;
      end else begin
        if (ord_we) vld_r[c0_r[HAP_W-1:0]] <= 1'b1;
        if (state_r == ST_FIN) site_r <= site_start;
      end
    end
  end

  // running maxima per class
  always_ff @(posedge clk) begin
    if (go_walk) begin
      run0_r <= site_start;
      run1_r <= site_start;
    end else if (zero_wr) begin
      run0_r <= '0;
      run1_r <= m1;
    end else if (one_wr) begin
      run0_r <= m0;
      run1_r <= '0;
    end
  end

  // pipeline payload
  always_ff @(posedge clk) begin
    vld_q_r <= vld_r[rd_addr];
    idx_q_r <= rd_addr;
    h_c_r   <= h_b;
    d_c_r   <= d_b;
  end

  always_ff @(posedge clk) begin
    if (ord_we) begin
      ord_mem[c0_r[HAP_W-1:0]] <= ord_wdata.hap;
      div_mem[c0_r[HAP_W-1:0]] <= ord_wdata.div;
    end
    ord_q_r <= ord_mem[rd_addr];
    div_q_r <= div_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (do_load) begin
      alle_mem[cmd.idx] <= cmd.allele;
    end
    all_q_r <= alle_mem[h_b];
  end

  always_ff @(posedge clk) begin
    if (one_wr) begin
      one_mem[c1_r[HAP_W-1:0]] <= '{hap: h_c_r, div: m1};
    end
    one_q_r <= one_mem[k_r[HAP_W-1:0]];
  end

endmodule

// File: rtl/core/pdu_chk.sv
`include "pbwt_prefix_divergence_update_top_defines.svh"

module pdu_chk (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_full,
  input logic                       out_empty,
  input logic                       out_pop,
  input logic [pdu_pkg::HAP_W-1:0]  out_hap_at_position,
  input logic [pdu_pkg::SITE_W-1:0] out_divergence,
  input logic [pdu_pkg::SITE_W-1:0] out_sites_done,
  input logic                       cfg_ready
);

  // both queues come out of reset drained
  `PDU_ASSERT_IMP(a_rst_drained, $past(!rst_n), out_empty && !in_full, "queues not drained after reset")

  // output still empty after reset, before any result can arrive
  `PDU_ASSERT_IMP(a_rst_no_early, $past(!rst_n, 2), out_empty, "result beat too soon after reset")

  // waiting result beat holds until popped
  `PDU_ASSERT_NXT(a_rsp_hold, !out_empty && !out_pop, !out_empty && $stable(out_hap_at_position) && $stable(out_divergence) && $stable(out_sites_done), "result beat changed while waiting")

  // config channel never back-pressures
  `PDU_ASSERT_IMP(a_cfg_open, 1'b1, cfg_ready, "config port not ready")

endmodule

bind pbwt_prefix_divergence_update_top pdu_chk u_pdu_chk (
  .clk                 (clk),
  .rst_n               (rst_n),
  .in_full             (in_full),
  .out_empty           (out_empty),
  .out_pop             (out_pop),
  .out_hap_at_position (out_hap_at_position),
  .out_divergence      (out_divergence),
  .out_sites_done      (out_sites_done),
  .cfg_ready           (cfg_ready)
);

// File: bench/pbwt_prefix_divergence_update_top_tb.sv
`timescale 1ns / 100ps

module pbwt_prefix_divergence_update_top_tb;
  import pdu_pkg::*;

  localparam int HOLD_CYCLES  = 400;        // receiver back-pressure stretch
  localparam int DRAIN_CYCLES = 600;        // longer than the worst-case close, with margin
  localparam int CYCLE_LIMIT  = 3_000_000;  // hard stop, well above the slowest clean run

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  // input queue side
  logic              in_push = 1'b0;
  logic              in_full;
  logic [OP_W-1:0]   in_op = '0;
  logic [HAP_W-1:0]  in_hap_index = '0;
  logic              in_allele = 1'b0;
  // result queue side
  logic              out_empty;
  logic              out_pop = 1'b0;
  logic [HAP_W-1:0]  out_hap_at_position;
  logic [SITE_W-1:0] out_divergence;
  logic [SITE_W-1:0] out_sites_done;
  // config
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [CFG_W-1:0]  cfg_num_haplotypes = NUM_HAPS_RST;

  pbwt_prefix_divergence_update_top DUT (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_push             (in_push),
    .in_full             (in_full),
    .in_op               (in_op),
    .in_hap_index        (in_hap_index),
    .in_allele           (in_allele),
    .out_empty           (out_empty),
    .out_pop             (out_pop),
    .out_hap_at_position (out_hap_at_position),
    .out_divergence      (out_divergence),
    .out_sites_done      (out_sites_done),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_num_haplotypes  (cfg_num_haplotypes)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Shadow copy of the PBWT state. Updated at the edge where a beat is taken,
  // so it always matches what the block has committed to, in order.
  // ---------------------------------------------------------------------------
  logic [HAP_W-1:0]  order_hap [MAX_HAPS];
  logic [SITE_W-1:0] order_div [MAX_HAPS];
  bit                allele_mem [MAX_HAPS];
  logic [SITE_W-1:0] site_count;
  logic [CFG_W-1:0]  haps_in_use;

  cmd_t cmd_backlog [$];     // commands waiting to go out on the input queue
  rsp_t expected_reads [$];  // read responses owed by the block, oldest first

  int in_beats = 0;      // written only by the beat monitor
  int offer_count = 0;   // written only by the driver
  int err_count = 0;
  int cmds_made = 0;

  bit steady = 1'b0;     // no idling on either side while set
  bit hold_ask = 1'b0;   // asks the receiver for one long hold-off
  bit hold_done = 1'b0;
  int hold_left = 0;

  // stimulus-side bookkeeping: which alleles have been loaded, so a close
  // never walks a haplotype whose allele was never written
  int  gen_haps;
  bit  loaded_haps [MAX_HAPS];
  int  load_bound = 0;
  int  covered_haps = 0;

  function automatic void restart_order();
    for (int k = 0; k < MAX_HAPS; k++) begin
      order_hap[k] = HAP_W'(k);
      order_div[k] = '0;
    end
    site_count = '0;
  endfunction

  // Stable split: allele-0 entries first, then allele-1. Each class carries a
  // running max of divergence, seeded at site+1 (saturating) and cleared after
  // every entry it emits.
  function automatic void partition_site();
    int n, c0, c1;
    logic [SITE_W-1:0] run0, run1, seed;
    logic [HAP_W-1:0]  h;
    logic [HAP_W-1:0]  zero_hap [MAX_HAPS];
    logic [HAP_W-1:0]  one_hap [MAX_HAPS];
    logic [SITE_W-1:0] zero_div [MAX_HAPS];
    logic [SITE_W-1:0] one_div [MAX_HAPS];
    n = (haps_in_use > MAX_HAPS) ? MAX_HAPS : int'(haps_in_use);
    seed = (site_count == SITE_MAX) ? SITE_MAX : site_count + 1'b1;
    run0 = seed;
    run1 = seed;
    c0 = 0;
    c1 = 0;
    for (int j = 0; j < n; j++) begin
      h = order_hap[j];
      if (order_div[j] > run0) run0 = order_div[j];
      if (order_div[j] > run1) run1 = order_div[j];
      if (!allele_mem[h]) begin
        zero_hap[c0] = h;
        zero_div[c0] = run0;
        run0 = '0;
        c0++;
      end else begin
        one_hap[c1] = h;
        one_div[c1] = run1;
        run1 = '0;
        c1++;
      end
    end
    for (int j = 0; j < c0; j++) begin
      order_hap[j] = zero_hap[j];
      order_div[j] = zero_div[j];
    end
    for (int j = 0; j < c1; j++) begin
      order_hap[c0 + j] = one_hap[j];
      order_div[c0 + j] = one_div[j];
    end
    if (site_count != SITE_MAX) site_count++;
  endfunction

  function automatic void advance_pbwt(cmd_t c);
    rsp_t r;
    case (c.op)
      OP_LOAD: begin
        allele_mem[c.idx] = c.allele;
      end
      OP_CLOSE: begin
        partition_site();
      end
      OP_READ: begin
        r.hap   = order_hap[c.idx];
        r.div   = order_div[c.idx];
        r.sites = site_count;
        expected_reads.push_back(r);
      end
      default: begin
        restart_order();
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus builders. They only append to the backlog; the driver paces it.
  // ---------------------------------------------------------------------------
  task automatic push_cmd(op_t op, int idx, bit al);
    cmd_t c;
    c.op = op;
    c.idx = HAP_W'(idx);
    c.allele = al;
    cmd_backlog.push_back(c);
    cmds_made++;
    if (op == OP_LOAD) loaded_haps[idx] = 1'b1;
  endtask

  // Every haplotype that can sit in the walked part of the order must have an
  // allele. Positions below the largest close width ever used hold exactly
  // haplotypes 0..bound-1, so loading all of those is enough.
  task automatic push_close();
    int eff;
    eff = (gen_haps > MAX_HAPS) ? MAX_HAPS : gen_haps;
    if (eff > load_bound) load_bound = eff;
    for (int h = covered_haps; h < load_bound; h++)
      if (!loaded_haps[h]) push_cmd(OP_LOAD, h, 1'($urandom_range(0, 1)));
    if (load_bound > covered_haps) covered_haps = load_bound;
    push_cmd(OP_CLOSE, $urandom_range(0, 255), 1'($urandom_range(0, 1)));
  endtask

  // one well-formed site: every active haplotype loaded, close, then reads
  task automatic push_site();
    int eff, pattern;
    bit al;
    eff = (gen_haps > MAX_HAPS) ? MAX_HAPS : gen_haps;
    pattern = $urandom_range(0, 3);
    for (int h = 0; h < eff; h++) begin
      case (pattern)
        0: al = 1'($urandom_range(0, 1));
        1: al = 1'b0;
        2: al = 1'b1;
        default: al = ($urandom_range(0, 3) != 0);
      endcase
      push_cmd(OP_LOAD, h, al);
    end
    push_close();
    repeat ($urandom_range(1, 3))
      push_cmd(OP_READ, (eff > 0) ? $urandom_range(0, eff - 1) : $urandom_range(0, 255),
               1'($urandom_range(0, 1)));
  endtask

  // mostly well-formed sites, the rest noise: stray loads, partial sites,
  // reads anywhere, restarts
  task automatic push_mix(int count);
    int start, pick;
    start = cmds_made;
    push_site();
    while (cmds_made - start < count) begin
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        push_site();
      end else if (pick < 75) begin
        push_cmd(OP_READ, $urandom_range(0, 255), 1'($urandom_range(0, 1)));
      end else if (pick < 88) begin
        push_cmd(OP_LOAD, $urandom_range(0, 255), 1'($urandom_range(0, 1)));
      end else if (pick < 95) begin
        repeat ($urandom_range(0, 4))
          push_cmd(OP_LOAD, $urandom_range(0, 255), 1'($urandom_range(0, 1)));
        push_close();
      end else begin
        push_cmd(OP_RESTART, $urandom_range(0, 255), 1'($urandom_range(0, 1)));
      end
    end
    // a trailing read proves everything before it has been executed
    push_cmd(OP_READ, $urandom_range(0, 255), 1'($urandom_range(0, 1)));
  endtask

  task automatic drain();
    while (cmd_backlog.size() != 0 || expected_reads.size() != 0) @(posedge clk);
    // closes make no result beat; give the back end time to finish one
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // only called with the block idle
  task automatic set_haps(int value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_num_haplotypes <= CFG_W'(value);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    gen_haps = value;
  endtask

  // ---------------------------------------------------------------------------
  // Driver: new beat decisions at the falling edge. A beat on offer is held
  // until the monitor has seen it taken.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (!rst_n) begin
      in_push <= 1'b0;
    end else if (!(in_push && offer_count != in_beats)) begin
      if (cmd_backlog.size() != 0 && (steady || $urandom_range(0, 99) >= 38)) begin
        in_push      <= 1'b1;
        in_op        <= cmd_backlog[0].op;
        in_hap_index <= cmd_backlog[0].idx;
        in_allele    <= cmd_backlog[0].allele;
        offer_count++;
      end else begin
        in_push <= 1'b0;
      end
    end
  end

  // Receiver: random pop, plus one long hold-off so the result queue and then
  // the command queue back up and in_full rises.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else if (hold_left != 0) begin
      out_pop <= 1'b0;
      hold_left--;
      if (hold_left == 0) hold_done = 1'b1;
    end else if (hold_ask && !hold_done) begin
      out_pop <= 1'b0;
      hold_left = HOLD_CYCLES;
    end else begin
      out_pop <= steady || ($urandom_range(0, 99) >= 38);
    end
  end

  // Beat monitor: sampled at the rising edge, before the block's own updates
  // land. Input beats step the shadow model; result beats are checked.
  always @(posedge clk) begin
    cmd_t taken;
    rsp_t want;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) haps_in_use = cfg_num_haplotypes;
      if (in_push && !in_full) begin
        taken = cmd_backlog.pop_front();
        in_beats++;
        advance_pbwt(taken);
      end
      if (out_pop && !out_empty) begin
        if (expected_reads.size() == 0) begin
          err_count++;
          if (err_count <= 10)
            $display("result beat with no read pending: hap %0d div %0d sites %0d",
                     out_hap_at_position, out_divergence, out_sites_done);
        end else begin
          want = expected_reads.pop_front();
          if (out_hap_at_position !== want.hap || out_divergence !== want.div ||
              out_sites_done !== want.sites) begin
            err_count++;
            if (err_count <= 10)
              $display("read mismatch (exp/got): hap %0d/%0d div %0d/%0d sites %0d/%0d",
                       want.hap, out_hap_at_position, want.div, out_divergence,
                       want.sites, out_sites_done);
          end
        end
      end
    end
  end

  // watchdog
  initial begin
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("end of test: mismatches");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    for (int k = 0; k < MAX_HAPS; k++) begin
      allele_mem[k] = 1'b0;
      loaded_haps[k] = 1'b0;
    end
    restart_order();
    haps_in_use = NUM_HAPS_RST;
    gen_haps = int'(NUM_HAPS_RST);

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: 4 haplotypes, identity reads, both alleles, top index,
    // two closes, a restart
    set_haps(4);
    push_cmd(OP_READ, 0, 1'b0);
    push_cmd(OP_READ, 255, 1'b1);        // past num_haplotypes, identity entry
    push_cmd(OP_LOAD, 0, 1'b1);
    push_cmd(OP_LOAD, 1, 1'b0);
    push_cmd(OP_LOAD, 2, 1'b1);
    push_cmd(OP_LOAD, 3, 1'b0);
    push_cmd(OP_LOAD, 255, 1'b1);        // outside the active set
    push_close();
    for (int p = 0; p < 4; p++) push_cmd(OP_READ, p, 1'b0);
    push_cmd(OP_READ, 255, 1'b0);
    push_cmd(OP_LOAD, 1, 1'b1);
    push_cmd(OP_LOAD, 2, 1'b0);
    push_close();
    for (int p = 0; p < 4; p++) push_cmd(OP_READ, p, 1'b1);
    push_cmd(OP_RESTART, 255, 1'b1);     // order back to identity, site 0
    push_cmd(OP_READ, 3, 1'b0);
    push_cmd(OP_READ, 0, 1'b1);
    drain();

    set_haps(1);                         // a single haplotype
    push_mix(120);
    drain();

    // burst of reads with the receiver holding off: fills both queues
    set_haps(2);
    hold_ask = 1'b1;
    repeat (24) push_cmd(OP_READ, $urandom_range(0, 255), 1'($urandom_range(0, 1)));
    push_mix(120);
    drain();

    // back-to-back stretch, no idling on either side
    set_haps(16);
    steady = 1'b1;
    push_mix(220);
    drain();
    steady = 1'b0;

    set_haps(37);
    push_mix(200);
    drain();

    set_haps(256);                       // full capacity
    push_mix(200);
    drain();

    set_haps(0);                         // close walks nothing, site still counts
    push_mix(60);
    drain();

    set_haps(511);                       // above capacity, clamps to 256
    push_mix(200);
    drain();

    set_haps(5);
    push_mix(250);
    drain();

    set_haps(3);
    push_close();
    for (int p = 0; p < 3; p++) push_cmd(OP_READ, p, 1'b0);
    push_close();
    for (int p = 0; p < 3; p++) push_cmd(OP_READ, p, 1'b1);
    push_cmd(OP_RESTART, 0, 1'b0);
    push_cmd(OP_READ, 1, 1'b0);
    drain();

    if (err_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
